>>> rtl/uedf_pkg.sv
package uedf_pkg;

    localparam int REPORT_BYTES = 2048;

    // byte position saturates at REPORT_BYTES
    localparam int OFF_W = $clog2(REPORT_BYTES + 1);
    // block offsets reach at most 18 + 255 * 65535
    localparam int ADR_W = 24;

    localparam logic [OFF_W-1:0] OFF_LIMIT    = OFF_W'(REPORT_BYTES);
    localparam logic [OFF_W-1:0] OFF_DEV_LAST = OFF_W'(17);
    localparam logic [OFF_W-1:0] OFF_DEV_END  = OFF_W'(18);
    localparam logic [ADR_W-1:0] ADR_DEV_END  = ADR_W'(18);

    localparam logic [7:0] KIND_INTERFACE = 8'd4;
    localparam logic [7:0] KIND_ENDPOINT  = 8'd5;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CONFIG_VALUE     = 3'd0;
    localparam t_cfg_idx CFG_INTERFACE_NUMBER = 3'd1;
    localparam t_cfg_idx CFG_ALT_SETTING      = 3'd2;
    localparam t_cfg_idx CFG_DIRECTION_IN     = 3'd3;
    localparam t_cfg_idx CFG_TRANSFER_TYPE    = 3'd4;

    typedef struct packed {
        logic [7:0] report_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       found;
        logic [7:0] endpoint_address;
    } t_out_item;

    typedef struct packed {
        logic [7:0] config_value;
        logic [7:0] interface_number;
        logic [7:0] alt_setting;
        logic       direction_in;
        logic [1:0] transfer_type;
    } t_cfg;

endpackage

>>> rtl/uedf_core.sv
module uedf_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  uedf_pkg::t_in_item  i_item,
    input  uedf_pkg::t_cfg      i_cfg,
    output logic                o_emit,
    output uedf_pkg::t_out_item o_res
);

    logic [uedf_pkg::OFF_W-1:0] r_off, n_off;
    logic [7:0]                 r_cfgs, n_cfgs;
    logic [uedf_pkg::ADR_W-1:0] r_bstart, n_bstart;
    logic [uedf_pkg::ADR_W-1:0] r_bend, n_bend;
    logic [uedf_pkg::ADR_W-1:0] r_dstart, n_dstart;
    logic [7:0]                 r_kind, n_kind;
    logic [7:0]                 r_lenlo, n_lenlo;
    logic                       r_matched, n_matched;
    logic                       r_iseen, n_iseen;
    logic [7:0]                 r_cur_if, n_cur_if;
    logic [7:0]                 r_cur_alt, n_cur_alt;
    logic [7:0]                 r_cand, n_cand;
    logic                       r_ag, n_ag;
    logic [7:0]                 r_sublen, n_sublen;
    logic                       r_lastsub, n_lastsub;

    logic [uedf_pkg::ADR_W-1:0] pos_ext;
    logic [uedf_pkg::ADR_W-1:0] b_ext;
    logic [uedf_pkg::ADR_W-1:0] d_rel;
    logic [uedf_pkg::ADR_W-1:0] h_rel;
    logic [uedf_pkg::ADR_W-1:0] hdr_len;
    logic [uedf_pkg::ADR_W-1:0] blk_len;
    logic                       in_walk;
    logic                       in_hdr;
    logic                       ep_match;
    logic [7:0]                 b;

    assign b       = i_item.report_byte;
    assign pos_ext = {{(uedf_pkg::ADR_W - uedf_pkg::OFF_W){1'b0}}, r_off};
    assign b_ext   = {{(uedf_pkg::ADR_W - 8){1'b0}}, b};
    assign d_rel   = pos_ext - r_dstart;
    assign h_rel   = pos_ext - r_bstart;
    assign hdr_len = r_dstart - r_bstart;
    assign blk_len = r_bend - r_bstart;
    assign in_walk = (pos_ext >= r_dstart) && (d_rel < uedf_pkg::ADR_W'(4));
    assign in_hdr  = (pos_ext >= r_bstart) && (h_rel < uedf_pkg::ADR_W'(6));

    assign ep_match = r_iseen
                   && (r_cur_if == i_cfg.interface_number)
                   && (r_cur_alt == i_cfg.alt_setting)
                   && (r_cand[7] == i_cfg.direction_in)
                   && (b[1:0] == i_cfg.transfer_type);

    always_comb begin
        n_off     = r_off;
        n_cfgs    = r_cfgs;
        n_bstart  = r_bstart;
        n_bend    = r_bend;
        n_dstart  = r_dstart;
        n_kind    = r_kind;
        n_lenlo   = r_lenlo;
        n_matched = r_matched;
        n_iseen   = r_iseen;
        n_cur_if  = r_cur_if;
        n_cur_alt = r_cur_alt;
        n_cand    = r_cand;
        n_ag      = r_ag;
        n_sublen  = r_sublen;
        n_lastsub = r_lastsub;
        o_emit    = 1'b0;
        o_res     = '0;

        if (!r_ag && (r_off < uedf_pkg::OFF_LIMIT)) begin
            if (r_off < uedf_pkg::OFF_DEV_END) begin
                // device descriptor: only bNumConfigurations matters
                if (r_off == uedf_pkg::OFF_DEV_LAST) begin
                    n_cfgs   = b;
                    n_bstart = uedf_pkg::ADR_DEV_END;
                    if (b == 8'd0) begin
                        n_ag   = 1'b1;
                        o_emit = 1'b1;
                    end
                end
            end else if (r_matched) begin
                if (in_walk) begin
                    case (d_rel[1:0])
                        2'd0: begin
                            if (b < 8'd4) begin
                                n_ag   = 1'b1;
                                o_emit = 1'b1;
                            end else begin
                                n_sublen  = b;
                                n_lastsub = (r_dstart + b_ext) >= r_bend;
                            end
                        end
                        2'd1: n_kind = b;
                        2'd2: begin
                            if (r_kind == uedf_pkg::KIND_INTERFACE) begin
                                n_cur_if = b;
                                n_iseen  = 1'b1;
                            end else if (r_kind == uedf_pkg::KIND_ENDPOINT) begin
                                n_cand = b;
                            end
                        end
                        default: begin
                            if (r_kind == uedf_pkg::KIND_INTERFACE) begin
                                n_cur_alt = b;
                            end
                            if (r_kind == uedf_pkg::KIND_ENDPOINT && ep_match) begin
                                n_ag                   = 1'b1;
                                o_emit                 = 1'b1;
                                o_res.found            = 1'b1;
                                o_res.endpoint_address = r_cand;
                            end else if (r_lastsub) begin
                                n_ag   = 1'b1;
                                o_emit = 1'b1;
                            end else begin
                                n_dstart = r_dstart
                                         + {{(uedf_pkg::ADR_W - 8){1'b0}}, r_sublen};
                            end
                        end
                    endcase
                end
            end else if (in_hdr) begin
                case (h_rel[2:0])
                    3'd0: n_dstart = r_bstart + b_ext;
                    3'd2: n_lenlo  = b;
                    3'd3: n_bend   = r_bstart
                                   + {{(uedf_pkg::ADR_W - 16){1'b0}}, b, r_lenlo};
                    3'd5: begin
                        if (b == i_cfg.config_value) begin
                            n_matched = 1'b1;
                            n_iseen   = 1'b0;
                            // header shorter than the six header bytes that are parsed
                            if (hdr_len < uedf_pkg::ADR_W'(6)) begin
                                n_ag   = 1'b1;
                                o_emit = 1'b1;
                            end
                        end else begin
                            n_cfgs = r_cfgs - 8'd1;
                            if (n_cfgs == 8'd0 || blk_len < uedf_pkg::ADR_W'(6)) begin
                                n_ag   = 1'b1;
                                o_emit = 1'b1;
                            end else begin
                                n_bstart = r_bend;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (r_off < uedf_pkg::OFF_LIMIT) begin
            n_off = r_off + uedf_pkg::OFF_W'(1);
        end

        if (i_item.last_byte) begin
            if (!n_ag) begin
                o_emit = 1'b1;
            end
            n_off     = '0;
            n_cfgs    = '0;
            n_bstart  = '0;
            n_bend    = '0;
            n_dstart  = '0;
            n_kind    = '0;
            n_lenlo   = '0;
            n_matched = 1'b0;
            n_iseen   = 1'b0;
            n_cur_if  = '0;
            n_cur_alt = '0;
            n_cand    = '0;
            n_ag      = 1'b0;
            n_sublen  = '0;
            n_lastsub = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= '0;
            r_cfgs    <= '0;
            r_bstart  <= '0;
            r_bend    <= '0;
            r_dstart  <= '0;
            r_kind    <= '0;
            r_lenlo   <= '0;
            r_matched <= 1'b0;
            r_iseen   <= 1'b0;
            r_cur_if  <= '0;
            r_cur_alt <= '0;
            r_cand    <= '0;
            r_ag      <= 1'b0;
            r_sublen  <= '0;
            r_lastsub <= 1'b0;
        end else if (i_step) begin
            r_off     <= n_off;
            r_cfgs    <= n_cfgs;
            r_bstart  <= n_bstart;
            r_bend    <= n_bend;
            r_dstart  <= n_dstart;
            r_kind    <= n_kind;
            r_lenlo   <= n_lenlo;
            r_matched <= n_matched;
            r_iseen   <= n_iseen;
            r_cur_if  <= n_cur_if;
            r_cur_alt <= n_cur_alt;
            r_cand    <= n_cand;
            r_ag      <= n_ag;
            r_sublen  <= n_sublen;
            r_lastsub <= n_lastsub;
        end
    end

endmodule

>>> rtl/usb_endpoint_descriptor_finder.sv
// path: a deciding byte passes the input register, then the output register
// throughput: one byte per cycle; the input register stalls only while a result waits
// in the output register and the byte in hand produces another result
// reset: synchronous active low; clears parse state, both pipeline registers and
// sets the search registers to config 1, interface 0, alt 0, IN, interrupt
module usb_endpoint_descriptor_finder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  uedf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output uedf_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  uedf_pkg::t_cfg_idx  i_cfg_index,
    input  logic [7:0]          i_cfg_data
);

    logic               r_in_valid;
    uedf_pkg::t_in_item r_in_item;
    logic               r_out_valid;
    uedf_pkg::t_out_item r_out_item;
    uedf_pkg::t_cfg     r_cfg;

    logic                emit;
    uedf_pkg::t_out_item res;
    logic                adv;

    // byte moves on unless it has a result and the output slot stays full
    assign adv         = r_in_valid && (!emit || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    uedf_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_emit  (emit),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (adv && emit) begin
            r_out_item <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.config_value     <= 8'd1;
            r_cfg.interface_number <= 8'd0;
            r_cfg.alt_setting      <= 8'd0;
            r_cfg.direction_in     <= 1'b1;
            r_cfg.transfer_type    <= 2'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                uedf_pkg::CFG_CONFIG_VALUE:     r_cfg.config_value     <= i_cfg_data;
                uedf_pkg::CFG_INTERFACE_NUMBER: r_cfg.interface_number <= i_cfg_data;
                uedf_pkg::CFG_ALT_SETTING:      r_cfg.alt_setting      <= i_cfg_data;
                uedf_pkg::CFG_DIRECTION_IN:     r_cfg.direction_in     <= i_cfg_data[0];
                uedf_pkg::CFG_TRANSFER_TYPE:    r_cfg.transfer_type    <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/uedf_checker.sv
module uedf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input uedf_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input uedf_pkg::t_out_item o_out_item,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input uedf_pkg::t_cfg_idx  i_cfg_index,
    input logic [7:0]          i_cfg_data
);

    // reports closed minus results delivered
    logic signed [3:0] r_diff, n_diff;
    logic              last_in;
    logic              res_out;

    assign last_in = i_in_valid && o_in_ready && i_in_item.last_byte;
    assign res_out = o_out_valid && i_out_ready;

    always_comb begin
        n_diff = r_diff;
        if (last_in && !res_out) begin
            n_diff = r_diff + 4'sd1;
        end else if (!last_in && res_out) begin
            n_diff = r_diff - 4'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff <= '0;
        end else begin
            r_diff <= n_diff;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.found |-> o_out_item.endpoint_address == 8'd0)
        else $error("not-found result carries an address");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_diff >= -4'sd1)
        else $error("more than one result for a report");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_diff <= 4'sd2)
        else $error("report closed without a result");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind usb_endpoint_descriptor_finder uedf_checker u_uedf_checker (.*);

>>> tb/tb_usb_endpoint_descriptor_finder.sv
`timescale 1ns / 1ps

module tb_usb_endpoint_descriptor_finder;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    uedf_pkg::t_in_item   i_in_item;
    logic                 o_out_valid;
    logic                 i_out_ready;
    uedf_pkg::t_out_item  o_out_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    uedf_pkg::t_cfg_idx   i_cfg_index;
    logic [7:0]           i_cfg_data;

    usb_endpoint_descriptor_finder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    int cycles = 0;
    int errors = 0;
    int results_seen = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // search registers as the finder sees them
    logic [7:0] want_cfg;
    logic [7:0] want_if;
    logic [7:0] want_alt;
    logic       want_in;
    logic [1:0] want_type;

    // parse state of the finder
    int unsigned pos_cnt;
    logic [7:0]  cfg_left;
    int unsigned blk_base;
    int unsigned blk_limit;
    int unsigned desc_base;
    logic [7:0]  desc_type;
    logic [7:0]  total_lo;
    logic        in_target;
    logic        iface_valid;
    logic [7:0]  iface_cur;
    logic [7:0]  alt_cur;
    logic [7:0]  ep_addr;
    logic [7:0]  sub_len;
    logic        final_sub;
    logic        done;

    uedf_pkg::t_out_item expected_answers[$];

    function automatic void clear_search();
        pos_cnt = 0;
        cfg_left = '0;
        blk_base = 0;
        blk_limit = 0;
        desc_base = 0;
        desc_type = '0;
        total_lo = '0;
        in_target = 1'b0;
        iface_valid = 1'b0;
        iface_cur = '0;
        alt_cur = '0;
        ep_addr = '0;
        sub_len = '0;
        final_sub = 1'b0;
        done = 1'b0;
    endfunction

    function automatic void answer(logic hit, logic [7:0] addr);
        uedf_pkg::t_out_item r;
        done = 1'b1;
        r.found = hit;
        r.endpoint_address = hit ? addr : 8'h00;
        expected_answers.push_back(r);
    endfunction

    function automatic void header_field(int unsigned rel, logic [7:0] b);
        case (rel)
            0: desc_base = blk_base + b;
            2: total_lo = b;
            3: blk_limit = blk_base + {b, total_lo};
            5: begin
                if (b == want_cfg) begin
                    in_target = 1'b1;
                    iface_valid = 1'b0;
                    if (desc_base - blk_base < 6) answer(1'b0, 8'h00);
                end else begin
                    cfg_left = cfg_left - 8'd1;
                    if (cfg_left == 8'd0) answer(1'b0, 8'h00);
                    else if (blk_limit - blk_base < 6) answer(1'b0, 8'h00);
                    else blk_base = blk_limit;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void walk_field(int unsigned rel, logic [7:0] b);
        case (rel)
            0: begin
                if (b < 8'd4) begin
                    answer(1'b0, 8'h00);
                end else begin
                    sub_len = b;
                    final_sub = (desc_base + b) >= blk_limit;
                end
            end
            1: desc_type = b;
            2: begin
                if (desc_type == uedf_pkg::KIND_INTERFACE) begin
                    iface_cur = b;
                    iface_valid = 1'b1;
                end else if (desc_type == uedf_pkg::KIND_ENDPOINT) begin
                    ep_addr = b;
                end
            end
            default: begin
                if (desc_type == uedf_pkg::KIND_INTERFACE) begin
                    alt_cur = b;
                end else if (desc_type == uedf_pkg::KIND_ENDPOINT && iface_valid &&
                             iface_cur == want_if && alt_cur == want_alt &&
                             ep_addr[7] == want_in && b[1:0] == want_type) begin
                    answer(1'b1, ep_addr);
                    return;
                end
                if (final_sub) answer(1'b0, 8'h00);
                else desc_base = desc_base + sub_len;
            end
        endcase
    endfunction

    function automatic void parse_byte(uedf_pkg::t_in_item it);
        logic [7:0] b;
        int unsigned pos;
        b = it.report_byte;
        pos = pos_cnt;
        if (!done && pos < uedf_pkg::REPORT_BYTES) begin
            if (pos < 18) begin
                if (pos == 17) begin
                    cfg_left = b;
                    blk_base = 18;
                    if (b == 8'd0) answer(1'b0, 8'h00);
                end
            end else if (in_target) begin
                if (pos >= desc_base && pos - desc_base < 4) walk_field(pos - desc_base, b);
            end else if (pos >= blk_base && pos - blk_base < 6) begin
                header_field(pos - blk_base, b);
            end
        end
        if (pos_cnt < uedf_pkg::REPORT_BYTES) pos_cnt++;
        if (it.last_byte) begin
            if (!done) answer(1'b0, 8'h00);
            clear_search();
        end
    endfunction

    function automatic void load_register(uedf_pkg::t_cfg_idx idx, logic [7:0] data);
        case (idx)
            uedf_pkg::CFG_CONFIG_VALUE:     want_cfg = data;
            uedf_pkg::CFG_INTERFACE_NUMBER: want_if = data;
            uedf_pkg::CFG_ALT_SETTING:      want_alt = data;
            uedf_pkg::CFG_DIRECTION_IN:     want_in = data[0];
            uedf_pkg::CFG_TRANSFER_TYPE:    want_type = data[1:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("cycle %0d result %0d: %s", cycles, results_seen, what);
    endtask

    always @(posedge i_clk) begin : check_results
        uedf_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) parse_byte(i_in_item);
            if (i_cfg_valid && o_cfg_ready) load_register(i_cfg_index, i_cfg_data);
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0b addr=%02h",
                                              o_out_item.found, o_out_item.endpoint_address));
                end else begin
                    want = expected_answers.pop_front();
                    if (o_out_item.found !== want.found)
                        report_mismatch($sformatf("found %0b, expected %0b",
                                                  o_out_item.found, want.found));
                    if (o_out_item.endpoint_address !== want.endpoint_address)
                        report_mismatch($sformatf("endpoint_address %02h, expected %02h",
                                                  o_out_item.endpoint_address,
                                                  want.endpoint_address));
                end
            end
        end
    end

    // receiver: switches between always ready, coin flips, a fixed pattern and long stalls
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold_left = 0;
    int rx_tick = 0;
    logic rx_level = 1'b1;

    always @(negedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(50, 300);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= (rx_tick % 4) != 0;
            default: begin
                if (rx_hold_left == 0) begin
                    rx_level = !rx_level;
                    rx_hold_left = rx_level ? $urandom_range(1, 8) : $urandom_range(1, 16);
                end
                rx_hold_left--;
                i_out_ready <= rx_level;
            end
        endcase
    end

    // sender: bursts of items with gaps between them
    int burst_left = 0;

    task automatic send_byte(uedf_pkg::t_in_item it);
        if (burst_left == 0) begin
            if (i_in_valid) i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
        i_in_item <= it;
        i_in_valid <= 1'b1;
        burst_left--;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        if (i_in_valid) i_in_valid <= 1'b0;
        burst_left = 0;
        while (expected_answers.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(uedf_pkg::t_cfg_idx idx, logic [7:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_search(logic [7:0] cv, logic [7:0] ifn, logic [7:0] alt,
                              logic [7:0] dir, logic [7:0] xfer);
        wait_idle();
        write_reg(uedf_pkg::CFG_CONFIG_VALUE, cv);
        write_reg(uedf_pkg::CFG_INTERFACE_NUMBER, ifn);
        write_reg(uedf_pkg::CFG_ALT_SETTING, alt);
        write_reg(uedf_pkg::CFG_DIRECTION_IN, dir);
        write_reg(uedf_pkg::CFG_TRANSFER_TYPE, xfer);
    endtask

    // report under construction
    logic [7:0] rpt[$];
    int blk_at;

    function automatic void push_device(logic [7:0] nconf);
        repeat (17) rpt.push_back(8'($urandom));
        rpt.push_back(nconf);
    endfunction

    function automatic void open_config(int hlen, logic [7:0] value);
        blk_at = rpt.size();
        rpt.push_back(8'(hlen));
        rpt.push_back(8'h02);
        rpt.push_back(8'h00);
        rpt.push_back(8'h00);
        rpt.push_back(8'($urandom));
        rpt.push_back(value);
        for (int k = 6; k < hlen; k++) rpt.push_back(8'($urandom));
    endfunction

    function automatic void close_config();
        int total;
        total = rpt.size() - blk_at;
        rpt[blk_at + 2] = total[7:0];
        rpt[blk_at + 3] = total[15:8];
    endfunction

    function automatic void push_iface(logic [7:0] ifn, logic [7:0] alt);
        rpt.push_back(8'd9);
        rpt.push_back(uedf_pkg::KIND_INTERFACE);
        rpt.push_back(ifn);
        rpt.push_back(alt);
        repeat (5) rpt.push_back(8'($urandom));
    endfunction

    function automatic void push_endpoint(logic [7:0] addr, logic [7:0] attr);
        rpt.push_back(8'd7);
        rpt.push_back(uedf_pkg::KIND_ENDPOINT);
        rpt.push_back(addr);
        rpt.push_back(attr);
        repeat (3) rpt.push_back(8'($urandom));
    endfunction

    function automatic void push_other(int len, logic [7:0] kind);
        rpt.push_back(8'(len));
        rpt.push_back(kind);
        for (int k = 2; k < len; k++) rpt.push_back(8'($urandom));
    endfunction

    task automatic send_report();
        uedf_pkg::t_in_item it;
        for (int k = 0; k < rpt.size(); k++) begin
            it.report_byte = rpt[k];
            it.last_byte = (k == rpt.size() - 1);
            send_byte(it);
        end
        rpt.delete();
    endtask

    function automatic logic [7:0] near_value(logic [7:0] v);
        logic [7:0] r;
        r = 8'($urandom);
        return ($urandom_range(0, 3) != 0) ? v : r;
    endfunction

    // tests before the register tests use the reset search: config 1, interface 0, alt 0, IN, interrupt

    task automatic test_reset_defaults();
        push_device(1);
        open_config(9, 1);
        push_iface(0, 0);
        push_endpoint(8'h81, 8'h03);
        close_config();
        // bytes after the answer must be ignored
        open_config(9, 1);
        push_iface(0, 0);
        push_endpoint(8'h82, 8'h03);
        close_config();
        send_report();
    endtask

    task automatic test_no_configurations();
        push_device(0);
        repeat (10) rpt.push_back(8'($urandom));
        send_report();
    endtask

    task automatic test_config_skip();
        push_device(3);
        open_config(9, 2);
        push_iface(0, 0);
        push_endpoint(8'h81, 8'h03);
        close_config();
        open_config(9, 5);
        push_iface(0, 0);
        close_config();
        open_config(9, 1);
        push_iface(0, 0);
        push_endpoint(8'h82, 8'h03);
        close_config();
        send_report();
        // every block skipped
        push_device(2);
        open_config(9, 7);
        push_iface(0, 0);
        close_config();
        open_config(9, 8);
        push_endpoint(8'h81, 8'h03);
        close_config();
        send_report();
        // skip a block whose total length needs the high byte
        push_device(2);
        open_config(9, 7);
        push_other(255, 8'h30);
        close_config();
        open_config(9, 1);
        push_iface(0, 0);
        push_endpoint(8'h83, 8'h07);
        close_config();
        send_report();
    endtask

    task automatic test_walk_stops();
        // zero and too short sub-descriptor lengths
        for (int len = 0; len < 4; len++) begin
            push_device(1);
            open_config(9, 1);
            push_iface(0, 0);
            rpt.push_back(8'(len));
            repeat (6) rpt.push_back(8'($urandom));
            close_config();
            send_report();
        end
        // block end reached on an endpoint that does not match
        push_device(1);
        open_config(9, 1);
        push_iface(0, 0);
        push_endpoint(8'h02, 8'h03);
        close_config();
        repeat (5) rpt.push_back(8'($urandom));
        send_report();
        // block end reached on an interface
        push_device(1);
        open_config(9, 1);
        push_iface(0, 0);
        push_iface(3, 1);
        close_config();
        send_report();
    endtask

    task automatic test_endpoint_before_interface();
        push_device(1);
        open_config(9, 1);
        push_endpoint(8'h81, 8'h03);
        push_iface(0, 0);
        push_endpoint(8'h84, 8'h03);
        close_config();
        send_report();
        push_device(1);
        open_config(9, 1);
        push_endpoint(8'h81, 8'h03);
        close_config();
        send_report();
    endtask

    task automatic test_short_headers();
        push_device(1);
        open_config(5, 1);
        push_iface(0, 0);
        push_endpoint(8'h81, 8'h03);
        close_config();
        send_report();
        push_device(1);
        open_config(0, 1);
        push_iface(0, 0);
        close_config();
        send_report();
        // non-matching block shorter than a header
        push_device(2);
        open_config(9, 9);
        close_config();
        rpt[blk_at + 2] = 8'd5;
        rpt[blk_at + 3] = 8'd0;
        open_config(9, 1);
        push_iface(0, 0);
        push_endpoint(8'h81, 8'h03);
        close_config();
        send_report();
    endtask

    task automatic test_report_end();
        rpt.push_back(8'($urandom));
        send_report();
        repeat (11) rpt.push_back(8'($urandom));
        send_report();
        // report ends with the matched block, which holds no endpoint
        push_device(1);
        open_config(9, 1);
        push_iface(0, 0);
        close_config();
        send_report();
    endtask

    task automatic test_filters();
        push_device(1);
        open_config(9, 1);
        push_iface(1, 0);
        push_endpoint(8'h81, 8'h03);
        push_iface(0, 1);
        push_endpoint(8'h81, 8'h03);
        push_iface(0, 0);
        push_endpoint(8'h01, 8'h03);
        push_endpoint(8'h81, 8'h02);
        push_other(9, 8'h21);
        push_endpoint(8'h85, 8'hFF);
        close_config();
        send_report();
    endtask

    task automatic test_long_report();
        // endpoint past the byte limit is never seen
        push_device(1);
        open_config(9, 1);
        repeat (8) push_other(255, 8'h24);
        push_iface(0, 0);
        push_endpoint(8'h87, 8'h03);
        close_config();
        send_report();
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_reg(3'd5, 8'($urandom));
        write_reg(3'd6, 8'($urandom));
        write_reg(3'd7, 8'($urandom));
        set_search(8'h00, 8'hFF, 8'hFF, 8'hFE, 8'hFC);
        push_device(2);
        open_config(9, 1);
        close_config();
        open_config(9, 0);
        push_iface(8'hFF, 8'hFF);
        push_endpoint(8'h8F, 8'h00);
        push_endpoint(8'h0F, 8'hFC);
        close_config();
        send_report();
        set_search(8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFD);
        push_device(8'hFF);
        open_config(9, 8'hFF);
        push_iface(8'h00, 8'hFF);
        push_endpoint(8'h0A, 8'h01);
        push_endpoint(8'h8A, 8'h01);
        close_config();
        send_report();
    endtask

    task automatic build_random_report();
        int style;
        int nconf;
        int hlen;
        int at;
        style = $urandom_range(0, 9);
        if (style == 0) begin
            // plain noise
            repeat ($urandom_range(1, 48)) rpt.push_back(8'($urandom));
            return;
        end
        nconf = $urandom_range(1, 3);
        push_device(8'(($urandom_range(0, 15) == 0) ? $urandom : nconf));
        for (int c = 0; c < nconf; c++) begin
            hlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : 9;
            open_config(hlen, near_value(want_cfg));
            repeat ($urandom_range(0, 5)) begin
                case ($urandom_range(0, 6))
                    0, 1: push_iface(near_value(want_if), near_value(want_alt));
                    2, 3, 4: push_endpoint({want_in ^ ($urandom_range(0, 4) == 0),
                                            7'($urandom)},
                                           {6'($urandom),
                                            ($urandom_range(0, 3) == 0) ?
                                            2'($urandom) : want_type});
                    default: push_other($urandom_range(4, 12), 8'($urandom));
                endcase
            end
            close_config();
        end
        repeat ($urandom_range(0, 3)) rpt.push_back(8'($urandom));
        if (style == 1) begin
            // broken report: cut short or one byte damaged
            at = $urandom_range(0, rpt.size() - 1);
            case ($urandom_range(0, 2))
                0: while (rpt.size() > at + 1) void'(rpt.pop_back());
                1: rpt[at] = 8'($urandom_range(0, 3));
                default: rpt[at] = 8'($urandom);
            endcase
        end
    endtask

    task automatic test_random_reports();
        int sent;
        int reports;
        int phase;
        sent = 0;
        reports = 0;
        phase = 0;
        while (sent < 450) begin
            case (phase)
                0: set_search(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                1: set_search(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_search(8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom));
                    else
                        set_search(8'($urandom_range(0, 3)), 8'($urandom_range(0, 2)),
                                   8'($urandom_range(0, 1)), 8'($urandom),
                                   8'($urandom));
                end
            endcase
            repeat (2) begin
                build_random_report();
                sent += rpt.size();
                send_report();
                reports++;
            end
            phase++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        want_cfg = 8'd1;
        want_if = 8'd0;
        want_alt = 8'd0;
        want_in = 1'b1;
        want_type = 2'd3;
        clear_search();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_no_configurations();
        test_config_skip();
        test_walk_stops();
        test_endpoint_before_interface();
        test_short_headers();
        test_report_end();
        test_filters();
        test_long_report();
        test_register_extremes();
        test_random_reports();

        wait_idle();
        repeat (12) @(negedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
